// File: rtl/core/lugd_pkg.sv
`timescale 1ns / 1ps

package lugd_pkg;

	// byte values that bound the byte classes
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] LEAD2_MIN = 8'hC0;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD5_MIN = 8'hF8;
	localparam logic [7:0] LEAD6_MIN = 8'hFC;
	localparam logic [7:0] LEAD_END  = 8'hFE;
	localparam logic [1:0] CONT_TAG  = 2'b10;

	localparam int HELD_DEPTH  = 5;
	localparam int RAW_SLOTS   = 6;
	localparam int CP_W        = 31;
	localparam int LEN_W       = 3;
	localparam int QUEUE_DEPTH = 2;

	// one queued work item: raw bytes to give first, then an optional final glyph
	typedef struct packed {
		logic [RAW_SLOTS-1:0][7:0] raw_bytes;
		logic [LEN_W-1:0]          raw_cnt;
		logic                      has_final;
		logic [CP_W-1:0]           final_cp;
		logic [LEN_W-1:0]          final_len;
		logic                      final_raw;
	} lugd_cmd_t;

endpackage

// File: rtl/core/lugd_byte_if.sv
`timescale 1ns / 1ps

interface lugd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source(output valid, output in_byte, output end_of_string, input ready);
	modport sink(input valid, input in_byte, input end_of_string, output ready);
endinterface

// File: rtl/core/lugd_glyph_if.sv
`timescale 1ns / 1ps

interface lugd_glyph_if;
	logic        valid;
	logic        ready;
	logic [30:0] code_point;
	logic [2:0]  glyph_bytes;
	logic        is_raw;
	logic        last_of_run;

	modport source(output valid, output code_point, output glyph_bytes, output is_raw,
		output last_of_run, input ready);
	modport sink(input valid, input code_point, input glyph_bytes, input is_raw,
		input last_of_run, output ready);
endinterface

// File: rtl/core/lugd_front.sv
`timescale 1ns / 1ps

module lugd_front
	import lugd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	lugd_byte_if.sink      bytes,
	input  logic           full,
	output logic           push,
	output lugd_cmd_t      push_cmd
);

	typedef enum logic [1:0] {
		CLS_NUL,
		CLS_ASCII,
		CLS_RAW,
		CLS_LEAD
	} lugd_class_t;

	logic [7:0]       held_q [HELD_DEPTH];
	logic [LEN_W-1:0] exp_q;
	logic [LEN_W-1:0] cnt_q;

	logic [7:0]       b;
	logic             eos;
	logic             accept;
	logic             pending;
	logic             is_cont;
	lugd_class_t      cls;
	logic [LEN_W-1:0] lead_len;
	logic [LEN_W-1:0] b_pos;
	logic [LEN_W-1:0] exp_d;
	logic [LEN_W-1:0] cnt_d;
	logic             hold_write;
	logic [LEN_W-1:0] hold_idx;
	logic [CP_W-1:0]  decoded;
	lugd_cmd_t        cmd;

	assign b           = bytes.in_byte;
	assign eos         = bytes.end_of_string;
	assign bytes.ready = !full;
	assign accept      = bytes.valid && !full;

	assign pending = (exp_q != '0) && (cnt_q != '0) && (cnt_q < exp_q);
	assign is_cont = (b[7:6] == CONT_TAG);
	assign b_pos   = pending ? cnt_q : '0;

	// byte class and sequence length of a lead
	always_comb begin
		lead_len = 3'd6;
		if (b == 8'h00) begin
			cls = CLS_NUL;
		end else if (b inside {[8'h01:ASCII_MAX]}) begin
			cls = CLS_ASCII;
		end else if (b < LEAD2_MIN || b >= LEAD_END) begin
			cls = CLS_RAW;
		end else begin
			cls = CLS_LEAD;
		end
		if (b < LEAD3_MIN) lead_len = 3'd2;
		else if (b < LEAD4_MIN) lead_len = 3'd3;
		else if (b < LEAD5_MIN) lead_len = 3'd4;
		else if (b < LEAD6_MIN) lead_len = 3'd5;
	end

	// assemble the code point of a completed sequence
	always_comb begin
		case (exp_q)
			3'd2:    decoded = CP_W'({held_q[0][4:0], b[5:0]});
			3'd3:    decoded = CP_W'({held_q[0][3:0], held_q[1][5:0], b[5:0]});
			3'd4:    decoded = CP_W'({held_q[0][2:0], held_q[1][5:0], held_q[2][5:0],
				b[5:0]});
			3'd5:    decoded = CP_W'({held_q[0][1:0], held_q[1][5:0], held_q[2][5:0],
				held_q[3][5:0], b[5:0]});
			default: decoded = {held_q[0][0], held_q[1][5:0], held_q[2][5:0],
				held_q[3][5:0], held_q[4][5:0], b[5:0]};
		endcase
	end

	// work out the queued item and the next sequence state
	always_comb begin
		cmd        = '0;
		exp_d      = '0;
		cnt_d      = '0;
		hold_write = 1'b0;
		hold_idx   = '0;
		for (int i = 0; i < RAW_SLOTS; i++) begin
			if (i < HELD_DEPTH && LEN_W'(i) != b_pos) begin
				cmd.raw_bytes[i] = held_q[i];
			end else begin
				cmd.raw_bytes[i] = b;
			end
		end
		if (pending && is_cont) begin
			if (cnt_q + 3'd1 == exp_q) begin
				cmd.has_final = 1'b1;
				cmd.final_cp  = decoded;
				cmd.final_len = exp_q;
				cmd.final_raw = 1'b0;
			end else begin
				hold_write = 1'b1;
				hold_idx   = cnt_q;
				if (eos) begin
					cmd.raw_cnt = cnt_q + 3'd1;
				end else begin
					exp_d = exp_q;
					cnt_d = cnt_q + 3'd1;
				end
			end
		end else begin
			cmd.raw_cnt   = b_pos;
			cmd.final_cp  = CP_W'(b);
			cmd.final_len = 3'd1;
			case (cls)
				CLS_ASCII: begin
					cmd.has_final = 1'b1;
					cmd.final_raw = 1'b0;
				end
				CLS_RAW: begin
					cmd.has_final = 1'b1;
					cmd.final_raw = 1'b1;
				end
				CLS_LEAD: begin
					if (eos) begin
						cmd.raw_cnt = b_pos + 3'd1;
					end else begin
						hold_write = 1'b1;
						hold_idx   = '0;
						exp_d      = lead_len;
						cnt_d      = 3'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign push     = accept && (cmd.has_final || cmd.raw_cnt != '0);
	assign push_cmd = cmd;

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			exp_q <= exp_d;
			cnt_q <= cnt_d;
		end
	end

	// held bytes, no reset
	always_ff @(posedge clk) begin
		if (accept && hold_write) begin
			held_q[hold_idx] <= b;
		end
	end

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q == '0 |-> cnt_q == '0)
		else $error("held count nonzero with no sequence pending");

	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q != '0 |-> (cnt_q != '0 && cnt_q < exp_q))
		else $error("held count out of range for pending sequence");

endmodule

// File: rtl/core/lugd_fifo.sv
`timescale 1ns / 1ps

module lugd_fifo
	import lugd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lugd_cmd_t push_cmd,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output lugd_cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lugd_cmd_t      mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue pushed when full or popped when empty");

endmodule

// File: rtl/core/lugd_back.sv
`timescale 1ns / 1ps

module lugd_back
	import lugd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  lugd_cmd_t   head,
	output logic        pop,
	lugd_glyph_if.source glyphs
);

	logic [LEN_W-1:0] idx_q;
	logic             valid_q;
	logic [CP_W-1:0]  cp_q;
	logic [LEN_W-1:0] len_q;
	logic             raw_q;
	logic             last_q;

	logic [LEN_W-1:0] total;
	logic             is_last;
	logic             load;
	logic [CP_W-1:0]  cp_d;
	logic [LEN_W-1:0] len_d;
	logic             raw_d;

	assign total   = head.raw_cnt + LEN_W'(head.has_final);
	assign is_last = (idx_q + 3'd1 == total);
	assign load    = !empty && (!valid_q || glyphs.ready);
	assign pop     = load && is_last;

	// pick the glyph at the current position of the head item
	always_comb begin
		if (idx_q < head.raw_cnt) begin
			cp_d  = CP_W'(head.raw_bytes[idx_q]);
			len_d = 3'd1;
			raw_d = 1'b1;
		end else begin
			cp_d  = head.final_cp;
			len_d = head.final_len;
			raw_d = head.final_raw;
		end
	end

	// position within the head item and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= is_last ? '0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (glyphs.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= cp_d;
			len_q  <= len_d;
			raw_q  <= raw_d;
			last_q <= is_last;
		end
	end

	assign glyphs.valid       = valid_q;
	assign glyphs.code_point  = cp_q;
	assign glyphs.glyph_bytes = len_q;
	assign glyphs.is_raw      = raw_q;
	assign glyphs.last_of_run = last_q;

	a_idx_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> idx_q < total)
		else $error("glyph position past end of queued item");

endmodule

// File: rtl/core/lenient_utf8_glyph_decoder.sv
`timescale 1ns / 1ps
// a byte is written into the queue, then its first glyph into the output register
// throughput: one byte per cycle if the sink is ready and no byte yields two glyphs
// the output gives one glyph per cycle while ready, each glyph of a byte in turn
// the queue between byte front and glyph back absorbs bursts of fallback glyphs
// reset clears sequence state, queue and output valid; held bytes are not reset
module lenient_utf8_glyph_decoder
	import lugd_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	lugd_byte_if.sink    bytes,
	lugd_glyph_if.source glyphs
);

	logic      full;
	logic      push;
	logic      pop;
	logic      empty;
	lugd_cmd_t push_cmd;
	lugd_cmd_t head;

	lugd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lugd_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	lugd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.glyphs (glyphs)
	);

endmodule
